// ===== rtl/core/ocsn_pkg.sv =====
`default_nettype none
package ocsn_pkg;

  // datapath operations issued by the controller, one per cycle unless it idles or waits on the output
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_PHASE,
    OP_MOD_INIT,
    OP_MOD_STEP,
    OP_ANGLE,
    OP_CORDIC,
    OP_SAVE,
    OP_BASIS,
    OP_SQUARE,
    OP_TERM,
    OP_ACCUM,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_FINISH
  } op_t;

  typedef struct packed {
    op_t        op;
    logic       axis;   // 0 x phase, 1 y phase
    logic [3:0] step;   // cordic iteration, or modulo step
  } cmd_t;

  typedef struct packed {
    logic need_div;
  } status_t;

  localparam logic [1:0] MODE_NORM   = 2'd0;
  localparam logic [1:0] MODE_ABS    = 2'd1;
  localparam logic [1:0] MODE_RIDGED = 2'd2;
  localparam logic [1:0] MODE_FOLD   = 2'd3;

  // register indexes on the config channel
  localparam logic [2:0] REG_MODE = 3'd0;
  localparam logic [2:0] REG_FREQ = 3'd1;
  localparam logic [2:0] REG_OCT  = 3'd2;
  localparam logic [2:0] REG_PERS = 3'd3;
  localparam logic [2:0] REG_LAC  = 3'd4;

  localparam logic [34:0] TWO_PI_Q32   = 35'd26986075409;
  localparam int          TWO_PI_Q16   = 411775;
  localparam int          PI_Q16       = 205887;
  localparam int          HALF_PI_Q16  = 102944;
  localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
  localparam int          CORDIC_STEPS = 16;
  localparam logic [16:0] ONE_Q16      = 17'd65536;

  // modulo 2*pi by reciprocal: multiply, multiply back, subtract, one fix-up
  localparam int          MOD_STEPS    = 3;
  localparam logic [3:0]  MOD_STEP_MUL = 4'd2;
  localparam logic [3:0]  MOD_STEP_SUB = 4'd1;
  // floor(2^64 / 2pi_q32), quotient estimate is (phase >> 24) * recip >> 40
  localparam logic [30:0] MOD_RECIP    = 31'((65'd1 << 64) / 65'(TWO_PI_Q32));

  // signed accumulator width for a given octave limit
  function automatic int acc_width(input int max_oct);
    return 18 + $clog2(max_oct);
  endfunction

  function automatic logic [15:0] atan_q16(input logic [3:0] k);
    logic [15:0] a;
    unique case (k)
      4'd0:    a = 16'd51472;
      4'd1:    a = 16'd30386;
      4'd2:    a = 16'd16055;
      4'd3:    a = 16'd8150;
      4'd4:    a = 16'd4091;
      4'd5:    a = 16'd2047;
      4'd6:    a = 16'd1024;
      4'd7:    a = 16'd512;
      4'd8:    a = 16'd256;
      4'd9:    a = 16'd128;
      4'd10:   a = 16'd64;
      4'd11:   a = 16'd32;
      4'd12:   a = 16'd16;
      4'd13:   a = 16'd8;
      4'd14:   a = 16'd4;
      default: a = 16'd2;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/ocsn_datapath.sv =====
`default_nettype none
module ocsn_datapath #(
  parameter int MAX_OCTAVES = 16
) (
  input  wire                   clk,
  input  wire ocsn_pkg::cmd_t   cmd,
  output ocsn_pkg::status_t     status,
  input  wire [1:0]             mode,
  input  wire [23:0]            base_frequency,
  input  wire [16:0]            persistence,
  input  wire [15:0]            lacunarity,
  input  wire signed [31:0]     x_coord,
  input  wire signed [31:0]     y_coord,
  output logic [16:0]           noise_value
);

  localparam int AW   = ocsn_pkg::acc_width(MAX_OCTAVES);
  localparam int GW   = 17 + $clog2(MAX_OCTAVES);
  localparam int DIVW = (GW + AW > 57) ? GW + AW + 1 : 57;

  logic signed [31:0] cx, cy;
  logic [23:0]        fq;
  logic [16:0]        gain;
  logic signed [AW-1:0] acc;
  logic [GW-1:0]      gsum;
  logic signed [56:0] pprod;
  logic               psign;
  logic [DIVW-1:0]    rem, dsh;
  logic [AW-1:0]      quo;
  logic [61:0]        qprod;
  logic [56:0]        mprod;
  logic signed [33:0] vx, vy;
  logic signed [19:0] z;
  logic               flip;
  logic signed [15:0] sn, cs;
  logic signed [17:0] nb, v;
  logic signed [34:0] tprod;
  logic [33:0]        gprod;
  logic [39:0]        fprod;

  logic [16:0]        pers_c;
  logic [56:0]        pmag;
  logic [34:0]        rr;
  logic signed [19:0] ang0, ang1, ang;
  logic               ang_flip;
  logic signed [33:0] dx, dy;
  logic signed [19:0] atan_s;
  logic [16:0]        nb_mag, m;
  logic [33:0]        msq;
  logic [27:0]        fq_new;
  logic [AW-2:0]      acc_mag;
  logic [DIVW-1:0]    numer;
  logic signed [AW+1:0] res;

  function automatic logic signed [15:0] to_q15(input logic signed [33:0] w);
    logic signed [33:0] t;
    t = (w + 34'sd16384) >>> 15;
    if (t > 34'sd32767) return 16'sd32767;
    if (t < -34'sd32767) return -16'sd32767;
    return t[15:0];
  endfunction

  assign status.need_div = (mode == ocsn_pkg::MODE_NORM) || (mode == ocsn_pkg::MODE_FOLD);
  assign pers_c = (persistence > ocsn_pkg::ONE_Q16) ? ocsn_pkg::ONE_Q16 : persistence;

  always_comb begin
    pmag = pprod[56] ? 57'(-pprod) : 57'(pprod);
    rr = (psign && rem != '0) ? ocsn_pkg::TWO_PI_Q32 - rem[34:0] : rem[34:0];
    ang0 = $signed({1'b0, rr[34:16]});
    ang1 = (ang0 > 20'(ocsn_pkg::PI_Q16)) ? ang0 - 20'(ocsn_pkg::TWO_PI_Q16) : ang0;
    ang_flip = 1'b0;
    ang = ang1;
    if (ang1 > 20'(ocsn_pkg::HALF_PI_Q16)) begin
      ang = 20'(ocsn_pkg::PI_Q16) - ang1;
      ang_flip = 1'b1;
    end else if (ang1 < -20'(ocsn_pkg::HALF_PI_Q16)) begin
      ang = -20'(ocsn_pkg::PI_Q16) - ang1;
      ang_flip = 1'b1;
    end
    dx = vy >>> cmd.step;
    dy = vx >>> cmd.step;
    atan_s = $signed({4'd0, ocsn_pkg::atan_q16(cmd.step)});
    nb_mag = nb[17] ? 17'(-nb) : 17'(nb);
    m = 17'(18'(ocsn_pkg::ONE_Q16) - 18'(nb_mag));
    msq = m * m;
    fq_new = 28'((fprod + 40'd2048) >> 12);
    acc_mag = acc[AW-1] ? (AW-1)'(-acc) : (AW-1)'(acc);
    numer = (mode == ocsn_pkg::MODE_NORM) ? (DIVW'(acc_mag) << 15) : (DIVW'(acc_mag) << 16);
    numer = numer + DIVW'(gsum >> 1);
    if (mode == ocsn_pkg::MODE_NORM)
      res = (AW+2)'(32768) + (acc[AW-1] ? -$signed({2'b0, quo}) : $signed({2'b0, quo}));
    else if (mode == ocsn_pkg::MODE_FOLD)
      res = (AW+2)'(65536) - $signed({2'b0, quo});
    else
      res = (AW+2)'(acc);
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      ocsn_pkg::OP_LOAD: begin
        cx   <= x_coord;
        cy   <= y_coord;
        fq   <= base_frequency;
        gain <= ocsn_pkg::ONE_Q16;
        acc  <= '0;
        gsum <= '0;
      end
      ocsn_pkg::OP_PHASE: begin
        pprod <= (cmd.axis ? cy : cx) * $signed({1'b0, fq});
      end
      ocsn_pkg::OP_MOD_INIT: begin
        psign <= pprod[56];
        rem   <= DIVW'(pmag);
        // |phase| < 2^55, so bits 54:24 carry everything the estimate needs
        qprod <= pmag[54:24] * ocsn_pkg::MOD_RECIP;
      end
      ocsn_pkg::OP_MOD_STEP: begin
        // estimate is the true quotient or one below it
        if (cmd.step == ocsn_pkg::MOD_STEP_MUL)
          mprod <= qprod[61:40] * ocsn_pkg::TWO_PI_Q32;
        else if (cmd.step == ocsn_pkg::MOD_STEP_SUB)
          rem <= rem - DIVW'(mprod);
        else if (rem >= DIVW'(ocsn_pkg::TWO_PI_Q32))
          rem <= rem - DIVW'(ocsn_pkg::TWO_PI_Q32);
      end
      ocsn_pkg::OP_DIV_STEP: begin
        if (rem >= dsh) begin
          rem <= rem - dsh;
          quo <= {quo[AW-2:0], 1'b1};
        end else begin
          quo <= {quo[AW-2:0], 1'b0};
        end
        dsh <= dsh >> 1;
      end
      ocsn_pkg::OP_ANGLE: begin
        z    <= ang;
        flip <= ang_flip;
        vx   <= ocsn_pkg::CORDIC_GAIN_Q30;
        vy   <= '0;
      end
      ocsn_pkg::OP_CORDIC: begin
        if (z >= 0) begin
          vx <= vx - dx;
          vy <= vy + dy;
          z  <= z - atan_s;
        end else begin
          vx <= vx + dx;
          vy <= vy - dy;
          z  <= z + atan_s;
        end
      end
      ocsn_pkg::OP_SAVE: begin
        if (!cmd.axis) sn <= to_q15(vy);
        else cs <= flip ? -to_q15(vx) : to_q15(vx);
      end
      ocsn_pkg::OP_BASIS: begin
        nb <= 18'((32'(sn * cs) + 32'sd8192) >>> 14);
      end
      ocsn_pkg::OP_SQUARE: begin
        if (mode == ocsn_pkg::MODE_RIDGED) v <= $signed(18'((35'(msq) + 35'd32768) >> 16));
        else if (mode == ocsn_pkg::MODE_ABS) v <= $signed({1'b0, nb_mag});
        else v <= nb;
      end
      ocsn_pkg::OP_TERM: begin
        tprod <= v * $signed({1'b0, gain});
        gprod <= gain * pers_c;
        fprod <= fq * lacunarity;
      end
      ocsn_pkg::OP_ACCUM: begin
        acc  <= acc + AW'((tprod + 35'sd32768) >>> 16);
        gsum <= gsum + GW'(gain);
        gain <= 17'((gprod + 34'd32768) >> 16);
        fq   <= (fq_new > 28'hFFFFFF) ? 24'hFFFFFF : fq_new[23:0];
      end
      ocsn_pkg::OP_DIV_INIT: begin
        rem <= numer;
        dsh <= DIVW'(gsum) << (AW - 1);
        quo <= '0;
      end
      ocsn_pkg::OP_FINISH: begin
        if (res < 0) noise_value <= '0;
        else if (res > (AW+2)'(65536)) noise_value <= ocsn_pkg::ONE_Q16;
        else noise_value <= res[16:0];
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/core/ocsn_ctrl.sv =====
`default_nettype none
module ocsn_ctrl #(
  parameter int MAX_OCTAVES = 16
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire                    out_ready,
  input  wire [4:0]              octave_count,
  input  wire ocsn_pkg::status_t status,
  output ocsn_pkg::cmd_t         cmd
);

  localparam int AW   = ocsn_pkg::acc_width(MAX_OCTAVES);
  localparam int NMAX = (AW > ocsn_pkg::MOD_STEPS) ? AW : ocsn_pkg::MOD_STEPS;
  localparam int SW   = $clog2(NMAX);
  localparam int OW   = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 1;

  typedef enum logic [3:0] {
    S_IDLE, S_PHASE, S_MODI, S_MOD, S_ANGLE, S_CORDIC, S_SAVE,
    S_BASIS, S_SQUARE, S_TERM, S_ACCUM, S_DIVI, S_DIV, S_FINISH
  } state_t;

  state_t        state;
  logic          axis;
  logic [SW-1:0] step;
  logic [OW-1:0] oct;
  logic [5:0]    cnt;
  logic [OW-1:0] last;
  logic          out_free;

  assign cnt = (octave_count == 5'd0) ? 6'd1 :
               ({1'b0, octave_count} > 6'(MAX_OCTAVES)) ? 6'(MAX_OCTAVES) :
               {1'b0, octave_count};
  assign last     = OW'(cnt - 6'd1);
  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd.axis = axis;
    cmd.step = step[3:0];
    unique case (state)
      S_IDLE:   cmd.op = in_valid ? ocsn_pkg::OP_LOAD : ocsn_pkg::OP_NONE;
      S_PHASE:  cmd.op = ocsn_pkg::OP_PHASE;
      S_MODI:   cmd.op = ocsn_pkg::OP_MOD_INIT;
      S_MOD:    cmd.op = ocsn_pkg::OP_MOD_STEP;
      S_ANGLE:  cmd.op = ocsn_pkg::OP_ANGLE;
      S_CORDIC: cmd.op = ocsn_pkg::OP_CORDIC;
      S_SAVE:   cmd.op = ocsn_pkg::OP_SAVE;
      S_BASIS:  cmd.op = ocsn_pkg::OP_BASIS;
      S_SQUARE: cmd.op = ocsn_pkg::OP_SQUARE;
      S_TERM:   cmd.op = ocsn_pkg::OP_TERM;
      S_ACCUM:  cmd.op = ocsn_pkg::OP_ACCUM;
      S_DIVI:   cmd.op = ocsn_pkg::OP_DIV_INIT;
      S_DIV:    cmd.op = ocsn_pkg::OP_DIV_STEP;
      S_FINISH: cmd.op = out_free ? ocsn_pkg::OP_FINISH : ocsn_pkg::OP_NONE;
      default:  cmd.op = ocsn_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      axis      <= 1'b0;
      step      <= '0;
      oct       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            axis  <= 1'b0;
            oct   <= '0;
            state <= S_PHASE;
          end
        end
        S_PHASE: state <= S_MODI;
        S_MODI: begin
          step  <= SW'(ocsn_pkg::MOD_STEPS - 1);
          state <= S_MOD;
        end
        S_MOD: begin
          if (step == '0) state <= S_ANGLE;
          else step <= step - 1'b1;
        end
        S_ANGLE: begin
          step  <= '0;
          state <= S_CORDIC;
        end
        S_CORDIC: begin
          if (step == SW'(ocsn_pkg::CORDIC_STEPS - 1)) state <= S_SAVE;
          else step <= step + 1'b1;
        end
        S_SAVE: begin
          if (!axis) begin
            axis  <= 1'b1;
            state <= S_PHASE;
          end else begin
            state <= S_BASIS;
          end
        end
        S_BASIS:  state <= S_SQUARE;
        S_SQUARE: state <= S_TERM;
        S_TERM:   state <= S_ACCUM;
        S_ACCUM: begin
          if (oct == last) begin
            state <= status.need_div ? S_DIVI : S_FINISH;
          end else begin
            oct   <= oct + 1'b1;
            axis  <= 1'b0;
            state <= S_PHASE;
          end
        end
        S_DIVI: begin
          step  <= SW'(AW - 1);
          state <= S_DIV;
        end
        S_DIV: begin
          if (step == '0) state <= S_FINISH;
          else step <= step - 1'b1;
        end
        S_FINISH: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == S_PHASE && !axis)
    else $error("accepted beat did not start an octave");

  a_finish_sets_valid: assert property (@(posedge clk) disable iff (rst)
    state == S_FINISH && out_free |=> out_valid && state == S_IDLE)
    else $error("finished sample not presented");

  a_octave_bound: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> oct <= last)
    else $error("octave index past configured count");

  a_cordic_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_CORDIC |-> step < SW'(ocsn_pkg::CORDIC_STEPS))
    else $error("cordic step out of range");

endmodule
`default_nettype wire

// ===== rtl/core/octave_sine_noise.sv =====
// channel   dir  handshake                 payload
// s_axis    in   s_tvalid / s_tready       x_coord, y_coord
// m_axis    out  m_tvalid / m_tready       noise_value
// cfg       in   cfg_valid / cfg_ready     cfg_index, cfg_data
//
// each octave runs, per axis, a phase multiply, reciprocal modulo 2*pi, angle fold,
// 16 cordic steps and a save; then basis, square, term and accumulate to combine;
// normalized and ridge-fold modes then add a restoring divide of acc_width quotient bits
// rst is synchronous; it clears the controller and loads the config defaults
// a finished result waits in the output register while the next beat is taken;
// a new result only stalls if the previous one is still not taken
`default_nettype none
module octave_sine_noise #(
  parameter int MAX_OCTAVES = 16
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire [63:0]  s_tdata,   // [31:0] x_coord, [63:32] y_coord
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [23:0] m_tdata,   // [16:0] noise_value, rest zero
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire [2:0]   cfg_index,
  input  wire [23:0]  cfg_data
);

  logic [1:0]  mode;
  logic [23:0] base_frequency;
  logic [4:0]  octave_count;
  logic [16:0] persistence;
  logic [15:0] lacunarity;

  ocsn_pkg::cmd_t    cmd;
  ocsn_pkg::status_t status;
  logic [16:0]       noise_value;

  // config writes are always taken; unknown indexes are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= '0;
      base_frequency <= 24'd65536;
      octave_count   <= 5'd4;
      persistence    <= 17'd32768;
      lacunarity     <= 16'd8192;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        ocsn_pkg::REG_MODE: mode           <= cfg_data[1:0];
        ocsn_pkg::REG_FREQ: base_frequency <= cfg_data;
        ocsn_pkg::REG_OCT:  octave_count   <= cfg_data[4:0];
        ocsn_pkg::REG_PERS: persistence    <= cfg_data[16:0];
        ocsn_pkg::REG_LAC:  lacunarity     <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  // sequencer: walks octaves, phase reduction, cordic and the final divide
  ocsn_ctrl #(.MAX_OCTAVES(MAX_OCTAVES)) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .octave_count (octave_count),
    .status       (status),
    .cmd          (cmd)
  );

  // arithmetic: multipliers, reciprocal modulo, restoring divider, cordic rotator
  ocsn_datapath #(.MAX_OCTAVES(MAX_OCTAVES)) u_dp (
    .clk            (clk),
    .cmd            (cmd),
    .status         (status),
    .mode           (mode),
    .base_frequency (base_frequency),
    .persistence    (persistence),
    .lacunarity     (lacunarity),
    .x_coord        ($signed(s_tdata[31:0])),
    .y_coord        ($signed(s_tdata[63:32])),
    .noise_value    (noise_value)
  );

  assign m_tdata = {7'd0, noise_value};

endmodule
`default_nettype wire

// ===== verif/octave_sine_noise_test.sv =====
`default_nettype none
module octave_sine_noise_test;

  // unmapped indexes of the config channel, must be ignored
  localparam logic [2:0] REG_NONE = 3'd6;
  localparam logic [2:0] REG_GAP5 = 3'd5;
  localparam logic [2:0] REG_GAP7 = 3'd7;

  // fixed point constants of the noise math
  localparam longint TWOPI_Q32 = 64'sd26986075409;
  localparam longint TWOPI_Q16 = 411775;
  localparam longint PI_Q16_L  = 205887;
  localparam longint HPI_Q16_L = 102944;
  localparam longint GAIN_Q30  = 652032874;
  localparam longint UNITY     = 65536;
  localparam int     OCT_LIMIT = 16;
  localparam int     STALL_LIMIT = 40000;

  localparam longint ATAN_TBL [16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                                       256, 128, 64, 32, 16, 8, 4, 2};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;  // [31:0] x_coord, [63:32] y_coord
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;       // [16:0] noise_value, rest zero
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [23:0] cfg_data = '0;

  octave_sine_noise u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // shadow copy of the config registers
  logic [1:0]  sh_mode = ocsn_pkg::MODE_NORM;
  logic [23:0] sh_base = 24'd65536;
  logic [4:0]  sh_oct  = 5'd4;
  logic [16:0] sh_pers = 17'd32768;
  logic [15:0] sh_lac  = 16'd8192;

  logic [16:0] noise_expected[$];
  int          error_count = 0;
  int          quiet_cycles = 0;
  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;

  initial forever #10 clk = ~clk;

  // q30 cordic output to q1.15, round half up, clamp symmetric
  function automatic longint round_q15(input longint v30);
    longint q;
    q = (v30 + 16384) >>> 15;
    if (q > 32767) q = 32767;
    if (q < -32767) q = -32767;
    return q;
  endfunction

  // sine and cosine of coord*freq after range reduction and quadrant fold
  function automatic void phase_sincos(input longint coord, input longint freq,
                                       output longint sn, output longint cs);
    longint rr, ang, vx, vy, z, dx, dy;
    bit     flip;
    flip = 1'b0;
    rr = (coord * freq) % TWOPI_Q32;
    if (rr < 0) rr += TWOPI_Q32;
    ang = rr >>> 16;
    if (ang > PI_Q16_L) ang -= TWOPI_Q16;
    if (ang > HPI_Q16_L) begin
      ang = PI_Q16_L - ang;
      flip = 1'b1;
    end else if (ang < -HPI_Q16_L) begin
      ang = -PI_Q16_L - ang;
      flip = 1'b1;
    end
    vx = GAIN_Q30;
    vy = 0;
    z = ang;
    for (int k = 0; k < 16; k++) begin
      dx = vy >>> k;
      dy = vx >>> k;
      if (z >= 0) begin
        vx -= dx; vy += dy; z -= ATAN_TBL[k];
      end else begin
        vx += dx; vy -= dy; z += ATAN_TBL[k];
      end
    end
    sn = round_q15(vy);
    cs = flip ? -round_q15(vx) : round_q15(vx);
  endfunction

  // fractal noise of one sample under the current shadow config
  function automatic logic [16:0] predict_noise(input logic [31:0] xr, input logic [31:0] yr);
    longint cx, cy, freq, gain, pers, acc, gsum, sx, cxx, sy, cy_cos, nb, mag, v, m, q, res;
    int     cnt;
    cx = $signed(xr);
    cy = $signed(yr);
    freq = sh_base;
    gain = UNITY;
    pers = (sh_pers > 17'd65536) ? UNITY : longint'(sh_pers);
    acc = 0;
    gsum = 0;
    cnt = sh_oct;
    if (cnt < 1) cnt = 1;
    if (cnt > OCT_LIMIT) cnt = OCT_LIMIT;
    for (int k = 0; k < cnt; k++) begin
      phase_sincos(cx, freq, sx, cxx);
      phase_sincos(cy, freq, sy, cy_cos);
      nb = (sx * cy_cos + 8192) >>> 14;
      mag = nb < 0 ? -nb : nb;
      if (sh_mode == ocsn_pkg::MODE_ABS) v = mag;
      else if (sh_mode == ocsn_pkg::MODE_RIDGED) begin
        m = UNITY - mag;
        v = (m * m + 32768) >>> 16;
      end else v = nb;
      acc += (v * gain + 32768) >>> 16;
      gsum += gain;
      gain = (gain * pers + 32768) >>> 16;
      freq = (freq * longint'(sh_lac) + 2048) >>> 12;
      if (freq > 64'hFFFFFF) freq = 64'hFFFFFF;
    end
    mag = acc < 0 ? -acc : acc;
    if (sh_mode == ocsn_pkg::MODE_NORM) begin
      q = (mag * 32768 + gsum / 2) / gsum;
      res = 32768 + (acc < 0 ? -q : q);
    end else if (sh_mode == ocsn_pkg::MODE_FOLD) begin
      q = (mag * UNITY + gsum / 2) / gsum;
      res = UNITY - q;
    end else res = acc;
    if (res < 0) res = 0;
    if (res > UNITY) res = UNITY;
    return res[16:0];
  endfunction

  // receiver back-pressure
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // result checker: each output beat against the oldest expectation
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (noise_expected.size() == 0) begin
        $display("%0t: unexpected result beat, actual %0d", $time, m_tdata);
        error_count++;
      end else begin
        logic [16:0] want;
        want = noise_expected.pop_front();
        if (m_tdata !== {7'd0, want}) begin
          $display("%0t: noise_value mismatch, expected %0d actual %0d",
                   $time, want, m_tdata);
          error_count++;
        end
      end
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // one sample beat, sometimes with a random gap in front
  task automatic send_sample(input logic [31:0] x, input logic [31:0] y);
    if ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
      repeat ($urandom_range(4)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {y, x};
    do @(posedge clk); while (!s_tready);
    noise_expected.push_back(predict_noise(x, y));
  endtask

  // sender holds off until every result is back
  task automatic drain;
    s_tvalid <= 1'b0;
    while (noise_expected.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [23:0] data);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      ocsn_pkg::REG_MODE: sh_mode = data[1:0];
      ocsn_pkg::REG_FREQ: sh_base = data;
      ocsn_pkg::REG_OCT:  sh_oct = data[4:0];
      ocsn_pkg::REG_PERS: sh_pers = data[16:0];
      ocsn_pkg::REG_LAC:  sh_lac = data[15:0];
      default: ;
    endcase
  endtask

  task automatic set_all(input logic [1:0] md, input logic [23:0] bf, input logic [4:0] oc,
                         input logic [16:0] pr, input logic [15:0] lc);
    write_reg(ocsn_pkg::REG_MODE, 24'(md));
    write_reg(ocsn_pkg::REG_FREQ, bf);
    write_reg(ocsn_pkg::REG_OCT, 24'(oc));
    write_reg(ocsn_pkg::REG_PERS, 24'(pr));
    write_reg(ocsn_pkg::REG_LAC, 24'(lc));
  endtask

  // coordinate extremes under reset config
  task automatic test_coord_extremes;
    send_sample(32'h0000_0000, 32'h0000_0000);
    send_sample(32'h7FFF_FFFF, 32'h8000_0000);
    send_sample(32'h8000_0000, 32'h7FFF_FFFF);
    send_sample(32'hFFFF_FFFF, 32'h0000_0001);
    send_sample(32'h0001_0000, 32'hFFFF_0000);
  endtask

  // each combine mode
  task automatic test_modes;
    for (int md = 0; md < 4; md++) begin
      set_all(md[1:0], 24'd102944, 5'd3, 17'd32768, 16'd8192);
      send_sample(32'h0000_C000, 32'hFFFE_8000);
      send_sample(32'h0003_2000, 32'h0000_4000);
    end
  endtask

  // octave count zero, the limit and beyond it
  task automatic test_octave_limits;
    set_all(ocsn_pkg::MODE_NORM, 24'd65536, 5'd0, 17'd40000, 16'd8192);
    send_sample(32'h0001_8000, 32'h0000_8000);
    write_reg(ocsn_pkg::REG_OCT, 24'd16);
    send_sample(32'h0001_8000, 32'h0000_8000);
    write_reg(ocsn_pkg::REG_OCT, 24'd31);
    send_sample(32'h0001_8000, 32'h0000_8000);
  endtask

  // persistence above one and zero gain
  task automatic test_gain_cases;
    set_all(ocsn_pkg::MODE_ABS, 24'd65536, 5'd5, 17'h1FFFF, 16'd6000);
    send_sample(32'h0002_3000, 32'h0000_1000);
    write_reg(ocsn_pkg::REG_PERS, 24'd65536);
    write_reg(ocsn_pkg::REG_MODE, 24'(ocsn_pkg::MODE_RIDGED));
    send_sample(32'h0002_3000, 32'h0000_1000);
    write_reg(ocsn_pkg::REG_PERS, 24'd0);
    write_reg(ocsn_pkg::REG_MODE, 24'(ocsn_pkg::MODE_FOLD));
    send_sample(32'h0002_3000, 32'h0000_1000);
  endtask

  // frequency overflow, zero frequency, zero lacunarity, unmapped index
  task automatic test_freq_and_index;
    set_all(ocsn_pkg::MODE_NORM, 24'hFFFFFF, 5'd4, 17'd32768, 16'hFFFF);
    send_sample(32'h1234_5678, 32'hEDCB_A987);
    set_all(ocsn_pkg::MODE_FOLD, 24'd0, 5'd2, 17'd32768, 16'd0);
    send_sample(32'h7FFF_FFFF, 32'h8000_0000);
    write_reg(REG_NONE, 24'hFFFFFF);
    write_reg(REG_GAP7, 24'd0);
    write_reg(REG_GAP5, 24'h123456);
    send_sample(32'h0000_8000, 32'h0000_8000);
  endtask

  function automatic logic [31:0] rand_coord;
    if ($urandom_range(3) == 0) return $urandom_range(32'h0008_0000) - 32'h0004_0000;
    return $urandom;
  endfunction

  // random configs, each followed by a burst of random samples
  task automatic test_random_bursts(input int tx_pct, input int rx_pct, input int n_items);
    int sent;
    logic [4:0]  oc;
    logic [23:0] bf;
    logic [16:0] pr;
    sent = 0;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    while (sent < n_items) begin
      case ($urandom_range(15))
        0: oc = 5'd16;
        1: oc = 5'($urandom_range(31));
        default: oc = 5'($urandom_range(1, 4));
      endcase
      bf = ($urandom_range(1) != 0) ? 24'($urandom_range(24'h040000)) : 24'($urandom);
      pr = ($urandom_range(7) == 0) ? 17'($urandom_range(17'h1FFFF)) :
                                      17'($urandom_range(65536));
      set_all(2'($urandom_range(3)), bf, oc, pr, 16'($urandom));
      repeat ($urandom_range(5, 30)) begin
        send_sample(rand_coord(), rand_coord());
        sent++;
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    tx_idle_pct = 13;
    rx_idle_pct = 49;
    test_coord_extremes();
    test_modes();
    test_octave_limits();
    test_gain_cases();
    test_freq_and_index();
    test_random_bursts(13, 49, 310);
    test_random_bursts(49, 13, 310);
    test_random_bursts(0, 0, 310);
    s_tvalid <= 1'b0;
    while (noise_expected.size() != 0) @(posedge clk);
    repeat (2000) @(posedge clk);
    if (error_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
`default_nettype wire
